>>> rtl/core/swsfr_pkg.sv
// Shared types, codes and defaults of the sliding-window sender.
`default_nettype none

package swsfr_pkg;

    // Defaults for the top-level parameters
    localparam int SEQ_COUNT_DEF    = 8;
    localparam int PAYLOAD_BITS_DEF = 64;

    // Fixed field widths of the channel words
    localparam int KIND_W     = 2;
    localparam int WORD_PL_W  = 64;
    localparam int FIELD_SEQ_W = 3;
    localparam int EVENT_W    = 4;
    localparam int WIN_W      = 3;
    localparam int TMO_W      = 32;
    localparam int DUP_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_SEND = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ACK  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK = 2'd2;

    // Result event codes
    localparam logic [EVENT_W-1:0] EV_SENT     = 4'd0;
    localparam logic [EVENT_W-1:0] EV_REFUSED  = 4'd1;
    localparam logic [EVENT_W-1:0] EV_SLID     = 4'd2;
    localparam logic [EVENT_W-1:0] EV_BAD_SUM  = 4'd3;
    localparam logic [EVENT_W-1:0] EV_DUP      = 4'd4;
    localparam logic [EVENT_W-1:0] EV_FAST_RTX = 4'd5;
    localparam logic [EVENT_W-1:0] EV_TIMEOUT  = 4'd6;
    localparam logic [EVENT_W-1:0] EV_IGNORED  = 4'd7;
    localparam logic [EVENT_W-1:0] EV_IDLE     = 4'd8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DUP_THR = 2'd2;

    // Configuration reset values and limits
    localparam logic [WIN_W-1:0] WINDOW_RST  = 3'd4;
    localparam logic [TMO_W-1:0] TIMEOUT_RST = 32'd20;
    localparam logic [DUP_W-1:0] DUP_THR_RST = 4'd3;
    localparam logic [DUP_W-1:0] DUP_MAX     = 4'd15;

    // Input word
    typedef struct packed {
        logic [KIND_W-1:0]      kind;
        logic [WORD_PL_W-1:0]   payload;
        logic [FIELD_SEQ_W-1:0] ack_number;
        logic                   ack_checksum_ok;
    } t_in_word;

    // Output word
    typedef struct packed {
        logic [EVENT_W-1:0]     event_res;
        logic                   tx_valid;
        logic [FIELD_SEQ_W-1:0] tx_seq;
        logic [WORD_PL_W-1:0]   tx_payload;
        logic [FIELD_SEQ_W-1:0] base_seq;
        logic [FIELD_SEQ_W-1:0] next_seq_out;
        logic [FIELD_SEQ_W-1:0] in_flight;
    } t_out_word;

    // Decision of one item, without payload, from control to the output path
    typedef struct packed {
        logic [EVENT_W-1:0]     event_res;
        logic                   tx_valid;
        logic [FIELD_SEQ_W-1:0] tx_seq;
        logic                   use_ram;
        logic [FIELD_SEQ_W-1:0] base_seq;
        logic [FIELD_SEQ_W-1:0] next_seq_out;
        logic [FIELD_SEQ_W-1:0] in_flight;
    } t_res;

endpackage

`default_nettype wire

>>> rtl/core/swsfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module swsfr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port, and read port that holds its data while not enabled
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/swsfr_ctrl.sv
// Window control: sequence counters, timer, duplicate count and config registers.
`default_nettype none

module swsfr_ctrl #(
    parameter int SEQ_COUNT    = swsfr_pkg::SEQ_COUNT_DEF,
    parameter int PAYLOAD_BITS = swsfr_pkg::PAYLOAD_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [swsfr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [swsfr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                             i_accept,
    input  wire swsfr_pkg::t_in_word              i_word,
    output logic                                  o_ram_we,
    output logic [$clog2(SEQ_COUNT)-1:0]          o_ram_waddr,
    output logic [PAYLOAD_BITS-1:0]               o_ram_wdata,
    output logic                                  o_ram_re,
    output logic [$clog2(SEQ_COUNT)-1:0]          o_ram_raddr,
    output swsfr_pkg::t_res                       o_res
);

    localparam int SW = $clog2(SEQ_COUNT);
    localparam logic [8:0]    SEQ_CNT9 = 9'(SEQ_COUNT);
    localparam logic [8:0]    WMAX9    = 9'(SEQ_COUNT - 1);
    localparam logic [SW-1:0] SEQ_SW   = SW'(SEQ_COUNT);
    localparam logic [SW-1:0] SEQ_LAST = SW'(SEQ_COUNT - 1);

    // Configuration registers
    logic [swsfr_pkg::WIN_W-1:0] r_window;
    logic [swsfr_pkg::TMO_W-1:0] r_timeout;
    logic [swsfr_pkg::DUP_W-1:0] r_dup_thr;

    // Window state
    logic [SW-1:0]               r_base,  n_base;
    logic [SW-1:0]               r_next,  n_next;
    logic [SW-1:0]               r_outst, n_outst;
    logic [swsfr_pkg::DUP_W-1:0] r_dup,   n_dup;
    logic                        r_run,   n_run;
    logic [swsfr_pkg::TMO_W-1:0] r_left,  n_left;

    logic [8:0]                  ack_red;
    logic [SW-1:0]               ack_m;
    logic [SW-1:0]               ack_inc;
    logic [SW-1:0]               next_inc;
    logic [SW-1:0]               prev;
    logic [SW:0]                 diff;
    logic [SW-1:0]               off;
    logic [SW-1:0]               eff_win;
    logic [swsfr_pkg::DUP_W-1:0] dup_inc;
    logic                        we;
    logic                        re;
    logic [SW-1:0]               tx_seq;

    // Reduce the ack number into the sequence space by repeated subtraction
    always_comb begin
        ack_red = {6'd0, i_word.ack_number};
        for (int i = 0; i < 8; i++) begin
            if (ack_red >= SEQ_CNT9) begin
                ack_red = ack_red - SEQ_CNT9;
            end
        end
    end

    assign ack_m = ack_red[SW-1:0];

    // Modular neighbors and offsets within the sequence space
    always_comb begin
        ack_inc  = (ack_m == SEQ_LAST) ? '0 : ack_m + 1'b1;
        next_inc = (r_next == SEQ_LAST) ? '0 : r_next + 1'b1;
        prev     = (r_base == '0) ? SEQ_LAST : r_base - 1'b1;
        diff     = {1'b0, ack_m} - {1'b0, r_base};
        off      = diff[SW] ? SW'(diff[SW-1:0] + SEQ_SW) : diff[SW-1:0];
        eff_win  = ({6'd0, r_window} > WMAX9) ? SEQ_LAST : SW'(r_window);
        dup_inc  = (r_dup == swsfr_pkg::DUP_MAX) ? r_dup : r_dup + 1'b1;
    end

    // Decide the item's event and next state
    always_comb begin
        n_base        = r_base;
        n_next        = r_next;
        n_outst       = r_outst;
        n_dup         = r_dup;
        n_run         = r_run;
        n_left        = r_left;
        we            = 1'b0;
        re            = 1'b0;
        tx_seq        = '0;
        o_res.event_res = swsfr_pkg::EV_IDLE;
        o_res.tx_valid  = 1'b0;
        o_res.use_ram   = 1'b0;
        case (i_word.kind)
            swsfr_pkg::KIND_SEND: begin
                if (r_outst >= eff_win) begin
                    o_res.event_res = swsfr_pkg::EV_REFUSED;
                end else begin
                    we = 1'b1;
                    if (r_outst == '0) begin
                        n_run  = 1'b1;
                        n_left = r_timeout;
                    end
                    o_res.tx_valid  = 1'b1;
                    tx_seq          = r_next;
                    n_next          = next_inc;
                    n_outst         = r_outst + 1'b1;
                    o_res.event_res = swsfr_pkg::EV_SENT;
                end
            end
            swsfr_pkg::KIND_ACK: begin
                if (!i_word.ack_checksum_ok) begin
                    o_res.event_res = swsfr_pkg::EV_BAD_SUM;
                end else if (off < r_outst) begin
                    n_base  = ack_inc;
                    n_outst = r_outst - off - 1'b1;
                    n_dup   = '0;
                    if (n_outst != '0) begin
                        n_run  = 1'b1;
                        n_left = r_timeout;
                    end else begin
                        n_run  = 1'b0;
                        n_left = '0;
                    end
                    o_res.event_res = swsfr_pkg::EV_SLID;
                end else if (ack_m == prev) begin
                    n_dup           = dup_inc;
                    o_res.event_res = swsfr_pkg::EV_DUP;
                    if (dup_inc == r_dup_thr && r_outst != '0) begin
                        o_res.tx_valid  = 1'b1;
                        o_res.use_ram   = 1'b1;
                        re              = 1'b1;
                        tx_seq          = r_base;
                        n_dup           = '0;
                        o_res.event_res = swsfr_pkg::EV_FAST_RTX;
                    end
                end else begin
                    o_res.event_res = swsfr_pkg::EV_IGNORED;
                end
            end
            swsfr_pkg::KIND_TICK: begin
                if (r_run && r_outst != '0) begin
                    if (r_left <= 32'd1) begin
                        n_run           = 1'b1;
                        n_left          = r_timeout;
                        o_res.tx_valid  = 1'b1;
                        o_res.use_ram   = 1'b1;
                        re              = 1'b1;
                        tx_seq          = r_base;
                        o_res.event_res = swsfr_pkg::EV_TIMEOUT;
                    end else begin
                        n_left = r_left - 1'b1;
                    end
                end
            end
            default: begin
                o_res.event_res = swsfr_pkg::EV_IDLE;
            end
        endcase
        o_res.tx_seq       = swsfr_pkg::FIELD_SEQ_W'(tx_seq);
        o_res.base_seq     = swsfr_pkg::FIELD_SEQ_W'(n_base);
        o_res.next_seq_out = swsfr_pkg::FIELD_SEQ_W'(n_next);
        o_res.in_flight    = swsfr_pkg::FIELD_SEQ_W'(n_outst);
    end

    // Store a sent payload under its sequence number; fetch the base for a resend
    assign o_ram_we    = i_accept & we;
    assign o_ram_waddr = r_next;
    assign o_ram_wdata = i_word.payload[PAYLOAD_BITS-1:0];
    assign o_ram_re    = i_accept & re;
    assign o_ram_raddr = r_base;

    // Advance window state on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_next  <= '0;
            r_outst <= '0;
            r_dup   <= '0;
            r_run   <= 1'b0;
            r_left  <= '0;
        end else if (i_accept) begin
            r_base  <= n_base;
            r_next  <= n_next;
            r_outst <= n_outst;
            r_dup   <= n_dup;
            r_run   <= n_run;
            r_left  <= n_left;
        end
    end

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window  <= swsfr_pkg::WINDOW_RST;
            r_timeout <= swsfr_pkg::TIMEOUT_RST;
            r_dup_thr <= swsfr_pkg::DUP_THR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                swsfr_pkg::CFG_WINDOW:  r_window  <= i_cfg_data[swsfr_pkg::WIN_W-1:0];
                swsfr_pkg::CFG_TIMEOUT: r_timeout <= i_cfg_data[swsfr_pkg::TMO_W-1:0];
                swsfr_pkg::CFG_DUP_THR: r_dup_thr <= i_cfg_data[swsfr_pkg::DUP_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/sliding_window_sender_fast_retransmit.sv
// Go-back-N sender with fast retransmit: control, payload RAM and result path.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_word) carries send requests,
//   acknowledgements and timer ticks; each word yields exactly one result word
//   on the output channel (o_out_valid / i_out_ready / o_out_word).
//   Configuration (window, timeout, duplicate threshold) is written through
//   i_cfg_we / i_cfg_idx / i_cfg_data while the block is idle.
// Timing:
//   One word is accepted per cycle, sustained while the output does not stall.
//   A result passes the pipeline register, which holds it while the payload RAM
//   reads the base packet on a resend, and then the output register.
//   The counters and timer update in the accept cycle, so the next word sees
//   them at once; the RAM write of a sent payload lands before any later read.
// Reset: synchronous, active low; window empty, timer stopped, configuration
//   back to defaults. Payload RAM content is not cleared (only written entries
//   are ever resent).
// Stall: the output register and the pipeline register in front of it hold
//   while i_out_ready is low; o_in_ready drops once both are full.
`default_nettype none

module sliding_window_sender_fast_retransmit #(
    parameter int SEQ_COUNT    = swsfr_pkg::SEQ_COUNT_DEF,
    parameter int PAYLOAD_BITS = swsfr_pkg::PAYLOAD_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [swsfr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [swsfr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire swsfr_pkg::t_in_word              i_in_word,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output swsfr_pkg::t_out_word                  o_out_word
);

    localparam int SW = $clog2(SEQ_COUNT);

    logic                    accept;
    logic                    ram_we;
    logic [SW-1:0]           ram_waddr;
    logic [PAYLOAD_BITS-1:0] ram_wdata;
    logic                    ram_re;
    logic [SW-1:0]           ram_raddr;
    logic [PAYLOAD_BITS-1:0] ram_rdata;
    swsfr_pkg::t_res         res;

    logic                    r_s1_valid;
    swsfr_pkg::t_res         r_s1_res;
    logic [PAYLOAD_BITS-1:0] r_s1_pl;
    logic                    s1_adv;
    swsfr_pkg::t_out_word    n_out_word;

    // Move words forward whenever the next stage frees up
    assign s1_adv     = r_s1_valid && (!o_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign accept     = i_in_valid && o_in_ready;

    swsfr_ctrl #(
        .SEQ_COUNT    (SEQ_COUNT),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_word      (i_in_word),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .o_res       (res)
    );

    swsfr_ram #(
        .WIDTH (PAYLOAD_BITS),
        .DEPTH (SEQ_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Hold the decision while the RAM read completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_res <= res;
            r_s1_pl  <= (res.tx_valid && !res.use_ram) ?
                        i_in_word.payload[PAYLOAD_BITS-1:0] : '0;
        end
    end

    // Resolve the transmitted payload from the RAM or the held send data
    always_comb begin
        n_out_word.event_res    = r_s1_res.event_res;
        n_out_word.tx_valid     = r_s1_res.tx_valid;
        n_out_word.tx_seq       = r_s1_res.tx_seq;
        n_out_word.tx_payload   = r_s1_res.use_ram ?
                                  swsfr_pkg::WORD_PL_W'(ram_rdata) :
                                  swsfr_pkg::WORD_PL_W'(r_s1_pl);
        n_out_word.base_seq     = r_s1_res.base_seq;
        n_out_word.next_seq_out = r_s1_res.next_seq_out;
        n_out_word.in_flight    = r_s1_res.in_flight;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (s1_adv) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            o_out_word <= n_out_word;
        end
    end

endmodule

`default_nettype wire
